>>> rtl/udpm_pkg.sv
// ----------------------------------------------------------------------------
// udpm_pkg
// Shared types, constants and helpers for the percent-decode pattern matcher.
// ----------------------------------------------------------------------------
package udpm_pkg;

  localparam int unsigned MaxPatternDefault = 16;
  localparam int unsigned PatBytes          = 15;
  localparam int unsigned PatWidth          = PatBytes * 8;
  localparam int unsigned CfgDataWidth      = 64;
  localparam int unsigned CfgIdxWidth       = 2;
  localparam int unsigned LenWidth          = 4;

  localparam logic [63:0] PatLowReset  = 64'h7261_6D2D_6C65_6B73;
  localparam logic [55:0] PatHighReset = 56'h00_0000_0072_656B;
  localparam logic [3:0]  PatLenReset  = 4'd11;

  localparam logic [7:0] CharPct  = 8'h25;
  localparam logic [7:0] CaseBit  = 8'h20;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpA  = 8'h41;
  localparam logic [7:0] CharUpZ  = 8'h5A;
  localparam logic [7:0] CharLoA  = 8'h61;
  localparam logic [7:0] CharLoF  = 8'h66;
  localparam logic [3:0] HexTen   = 4'd10;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_PAT_LOW  = 2'd0,
    REG_PAT_HIGH = 2'd1,
    REG_PAT_LEN  = 2'd2
  } reg_idx_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_END  = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    PH_IDLE = 3'b001,
    PH_PCT  = 3'b010,
    PH_HEX  = 3'b100
  } phase_e;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  typedef struct packed {
    logic       stream_end;
    logic [7:0] decoded_byte;
    logic       byte_valid;
    logic       matched;
  } result_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CharUpA && c <= CharUpZ) begin
      r = c | CaseBit;
    end
    return r;
  endfunction

  function automatic hex_t hex_value(input logic [7:0] ch);
    hex_t       h;
    logic [7:0] c;
    c     = ch | CaseBit;
    h.ok  = 1'b0;
    h.val = '0;
    if (ch >= CharZero && ch <= CharNine) begin
      h.ok  = 1'b1;
      h.val = ch[3:0];
    end else if (c >= CharLoA && c <= CharLoF) begin
      h.ok  = 1'b1;
      h.val = 4'(c - CharLoA) + HexTen;
    end
    return h;
  endfunction

endpackage

>>> rtl/udpm_match.sv
// ----------------------------------------------------------------------------
// udpm_match
// Parallel window compare of the decoded history against the pattern.
// ----------------------------------------------------------------------------
module udpm_match #(
  parameter int unsigned HistDepth = udpm_pkg::MaxPatternDefault - 1,
  parameter int unsigned CntWidth  = $clog2(HistDepth + 1)
) (
  input  logic [HistDepth-1:0][7:0]        hist_i,
  input  logic [CntWidth-1:0]              count_i,
  input  logic [udpm_pkg::PatWidth-1:0]    pattern_i,
  input  logic [udpm_pkg::LenWidth-1:0]    pattern_len_i,
  output logic                             hit_o
);

  logic [HistDepth-1:0][7:0] pat_lc;
  logic [HistDepth:1]        win;

  for (genvar i = 0; i < HistDepth; i++) begin : g_pat
    assign pat_lc[i] = udpm_pkg::to_lower(pattern_i[8*i +: 8]);
  end

  for (genvar l = 1; l <= HistDepth; l++) begin : g_win
    logic [HistDepth-1:0] eq;
    for (genvar i = 0; i < HistDepth; i++) begin : g_eq
      if (i < l) begin : g_cmp
        assign eq[i] = (pat_lc[i] == hist_i[l-1-i]);
      end else begin : g_pad
        assign eq[i] = 1'b1;
      end
    end
    assign win[l] = &eq;
  end

  always_comb begin
    hit_o = 1'b0;
    for (int l = 1; l <= HistDepth; l++) begin
      if (pattern_len_i == udpm_pkg::LenWidth'(l) && count_i >= CntWidth'(l) && win[l]) begin
        hit_o = 1'b1;
      end
    end
  end

endmodule

>>> rtl/uri_decode_pattern_matcher.sv
// ----------------------------------------------------------------------------
// uri_decode_pattern_matcher
// Percent-decodes a byte stream and flags a case-insensitive pattern hit.
//
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  tdata: data_byte; tuser: op
//  m_axis    out  m_axis_tvalid/m_axis_tready  tdata: matched, decoded_byte;
//                                              tuser: byte_valid; tlast: stream_end
//  cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
//  One word per cycle while m_axis_tready is high; results are registered.
//  Decode, history shift and the window compare sit between the input
//  handshake and the output register; a skid register absorbs one stalled word.
//  Reset clears the decoder, history fill count and match flag and loads the pattern
//  "skel-marker" with length 11. An end-of-stream word clears the same state.
// ----------------------------------------------------------------------------
module uri_decode_pattern_matcher #(
  parameter int unsigned MAX_PATTERN = udpm_pkg::MaxPatternDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // data_byte
  input  logic                               s_axis_tuser,  // op
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [15:0]                        m_axis_tdata,  // matched, decoded_byte
  output logic                               m_axis_tuser,  // byte_valid
  output logic                               m_axis_tlast,
  input  logic                               cfg_we_i,
  input  logic [udpm_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [udpm_pkg::CfgDataWidth-1:0]  cfg_data_i
);

  localparam int unsigned HistDepth = MAX_PATTERN - 1;
  localparam int unsigned CntWidth  = $clog2(HistDepth + 1);

  logic [63:0] pat_low_q;
  logic [55:0] pat_high_q;
  logic [3:0]  pat_len_q;

  udpm_pkg::phase_e          phase_q, phase_d;
  logic [3:0]                nib_q, nib_d;
  logic [HistDepth-1:0][7:0] hist_q, hist_new;
  logic [CntWidth-1:0]       cnt_q, cnt_new, cnt_d;
  logic                      match_q, match_d;

  udpm_pkg::hex_t    hex;
  udpm_pkg::result_t res, out_q, skid_q;
  logic              out_valid_q, skid_valid_q;
  logic              dec_valid, hit, accept, take, is_end;
  logic [7:0]        dec_raw, dec;

  assign s_axis_tready = !skid_valid_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign take          = out_valid_q && m_axis_tready;
  assign is_end        = (udpm_pkg::op_e'(s_axis_tuser) == udpm_pkg::OP_END);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= udpm_pkg::PatLowReset;
      pat_high_q <= udpm_pkg::PatHighReset;
      pat_len_q  <= udpm_pkg::PatLenReset;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        udpm_pkg::REG_PAT_LOW:  pat_low_q  <= cfg_data_i;
        udpm_pkg::REG_PAT_HIGH: pat_high_q <= cfg_data_i[55:0];
        udpm_pkg::REG_PAT_LEN:  pat_len_q  <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign hex = udpm_pkg::hex_value(s_axis_tdata);

  always_comb begin
    phase_d   = phase_q;
    nib_d     = nib_q;
    dec_valid = 1'b0;
    dec_raw   = s_axis_tdata;
    unique case (phase_q)
      udpm_pkg::PH_PCT: begin
        if (hex.ok) begin
          nib_d   = hex.val;
          phase_d = udpm_pkg::PH_HEX;
        end else begin
          phase_d   = udpm_pkg::PH_IDLE;
          dec_valid = 1'b1;
        end
      end
      udpm_pkg::PH_HEX: begin
        phase_d   = udpm_pkg::PH_IDLE;
        dec_valid = hex.ok;
        dec_raw   = {nib_q, hex.val};
      end
      default: begin
        if (s_axis_tdata == udpm_pkg::CharPct) begin
          phase_d = udpm_pkg::PH_PCT;
        end else begin
          phase_d   = udpm_pkg::PH_IDLE;
          dec_valid = 1'b1;
        end
      end
    endcase
  end

  assign dec = udpm_pkg::to_lower(dec_raw);

  assign hist_new[0] = dec;
  if (HistDepth > 1) begin : g_shift
    assign hist_new[HistDepth-1:1] = hist_q[HistDepth-2:0];
  end

  assign cnt_new = (cnt_q == CntWidth'(HistDepth)) ? cnt_q : cnt_q + 1'b1;

  udpm_match #(
    .HistDepth (HistDepth),
    .CntWidth  (CntWidth)
  ) u_match (
    .hist_i        (hist_new),
    .count_i       (cnt_new),
    .pattern_i     ({pat_high_q, pat_low_q}),
    .pattern_len_i (pat_len_q),
    .hit_o         (hit)
  );

  always_comb begin
    match_d = match_q | (dec_valid & hit);
    cnt_d   = dec_valid ? cnt_new : cnt_q;
    if (is_end) begin
      res.matched      = match_q;
      res.byte_valid   = 1'b0;
      res.decoded_byte = '0;
      res.stream_end   = 1'b1;
    end else begin
      res.matched      = match_d;
      res.byte_valid   = dec_valid;
      res.decoded_byte = dec_valid ? dec : 8'h00;
      res.stream_end   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= udpm_pkg::PH_IDLE;
      nib_q   <= '0;
      cnt_q   <= '0;
      match_q <= 1'b0;
    end else if (accept) begin
      if (is_end) begin
        phase_q <= udpm_pkg::PH_IDLE;
        nib_q   <= '0;
        cnt_q   <= '0;
        match_q <= 1'b0;
      end else begin
        phase_q <= phase_d;
        nib_q   <= nib_d;
        cnt_q   <= cnt_d;
        match_q <= match_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && !is_end && dec_valid) begin
      hist_q <= hist_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || take) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= accept;
      end
    end else if (accept) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || take) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (accept && out_valid_q && !take) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0, out_q.decoded_byte, out_q.matched};
  assign m_axis_tuser  = out_q.byte_valid;
  assign m_axis_tlast  = out_q.stream_end;

`ifndef SYNTH
  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held without output word");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_end) |=> (phase_q == udpm_pkg::PH_IDLE && cnt_q == '0 && !match_q))
    else $error("state not cleared after end of stream");

  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> (!m_axis_tuser && m_axis_tdata[8:1] == 8'h00))
    else $error("end-of-stream word carries a byte");

  a_match_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q && !(accept && is_end)) |=> match_q)
    else $error("match flag dropped inside a stream");
`endif

endmodule

>>> dv/udpm_stream_checker.sv
// ----------------------------------------------------------------------------
// udpm_stream_checker
// Watches the input, output and register channels of the percent-decode
// pattern matcher. Predicts one result word per accepted input word from its
// own copy of the decoder, history, match flag and pattern registers, and
// compares every returned word with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module udpm_stream_checker
  import udpm_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    s_axis_tvalid,
  input  logic                    s_axis_tready,
  input  logic [7:0]              s_axis_tdata,  // data_byte
  input  logic                    s_axis_tuser,  // op
  input  logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  input  logic [15:0]             m_axis_tdata,  // matched, decoded_byte
  input  logic                    m_axis_tuser,  // byte_valid
  input  logic                    m_axis_tlast,  // stream_end
  input  logic                    cfg_we_i,
  input  logic [CfgIdxWidth-1:0]  cfg_idx_i,
  input  logic [CfgDataWidth-1:0] cfg_data_i,
  output int                      fail_count,
  output int                      outstanding,
  output int                      results_seen,
  output int                      streams_closed,
  output int                      stream_hits
);

  localparam int unsigned HistDepth = MaxPatternDefault - 1;

  typedef enum logic [1:0] {
    DEC_PLAIN,
    DEC_PERCENT,
    DEC_NIBBLE
  } dec_phase_e;

  typedef struct packed {
    logic       stream_end;
    logic [7:0] byte_out;
    logic       byte_valid;
    logic       matched;
  } decode_word_t;

  logic [63:0]  pat_low;
  logic [55:0]  pat_high;
  logic [3:0]   pat_len;
  dec_phase_e   phase;
  logic [3:0]   high_nibble;
  logic [7:0]   history [HistDepth];
  int unsigned  hist_fill;
  logic         seen_hit;
  decode_word_t pending_decodes [$];

  function automatic int unsigned hex_weight(input logic [7:0] c);
    logic [7:0] folded;
    folded = c | CaseBit;
    if (c >= CharZero && c <= CharNine) return c - CharZero;
    if (folded >= CharLoA && folded <= CharLoF) return folded - CharLoA + 10;
    return 16;
  endfunction

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    return (c >= CharUpA && c <= CharUpZ) ? (c | CaseBit) : c;
  endfunction

  function automatic logic [7:0] pattern_char(input int unsigned i);
    if (i < 8) return pat_low[8*i +: 8];
    return pat_high[8*(i-8) +: 8];
  endfunction

  function automatic void clear_stream();
    phase       = DEC_PLAIN;
    high_nibble = '0;
    hist_fill   = 0;
    seen_hit    = 1'b0;
    for (int i = 0; i < HistDepth; i++) history[i] = '0;
  endfunction

  function automatic decode_word_t decode_and_match(input logic op, input logic [7:0] raw);
    decode_word_t r;
    int unsigned  w;
    logic         emit;
    logic [7:0]   b;
    logic         hit;
    r    = '0;
    emit = 1'b0;
    b    = '0;
    w    = hex_weight(raw);
    if (op == OP_END) begin
      r.matched    = seen_hit;
      r.stream_end = 1'b1;
      clear_stream();
      return r;
    end
    case (phase)
      DEC_PERCENT: begin
        if (w < 16) begin
          high_nibble = w[3:0];
          phase       = DEC_NIBBLE;
        end else begin
          phase = DEC_PLAIN;
          emit  = 1'b1;
          b     = raw;
        end
      end
      DEC_NIBBLE: begin
        phase = DEC_PLAIN;
        if (w < 16) begin
          emit = 1'b1;
          b    = {high_nibble, w[3:0]};
        end
      end
      default: begin
        if (raw == CharPct) begin
          phase = DEC_PERCENT;
        end else begin
          emit = 1'b1;
          b    = raw;
        end
      end
    endcase
    if (emit) begin
      b = fold_case(b);
      for (int i = HistDepth - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = b;
      if (hist_fill < HistDepth) hist_fill++;
      if (pat_len != 0 && pat_len <= hist_fill) begin
        hit = 1'b1;
        for (int i = 0; i < pat_len; i++) begin
          if (fold_case(pattern_char(i)) != history[pat_len - 1 - i]) hit = 1'b0;
        end
        if (hit) seen_hit = 1'b1;
      end
    end
    r.matched    = seen_hit;
    r.byte_valid = emit;
    r.byte_out   = emit ? b : '0;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at %0t, result %0d: %s got 'h%0h, want 'h%0h",
             $time, results_seen, field, got, want);
    fail_count++;
  endtask

  task automatic check_result();
    decode_word_t want;
    if (pending_decodes.size() == 0) begin
      report_mismatch("word with nothing pending", m_axis_tdata, '0);
      return;
    end
    want = pending_decodes.pop_front();
    results_seen++;
    if (m_axis_tdata[0] !== want.matched)
      report_mismatch("matched", m_axis_tdata[0], want.matched);
    if (m_axis_tuser !== want.byte_valid)
      report_mismatch("byte_valid", m_axis_tuser, want.byte_valid);
    if (m_axis_tdata[8:1] !== want.byte_out)
      report_mismatch("decoded_byte", m_axis_tdata[8:1], want.byte_out);
    if (m_axis_tdata[15:9] !== '0)
      report_mismatch("tdata padding", m_axis_tdata[15:9], '0);
    if (m_axis_tlast !== want.stream_end)
      report_mismatch("stream_end", m_axis_tlast, want.stream_end);
    if (want.stream_end) begin
      streams_closed++;
      if (want.matched) stream_hits++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low  = PatLowReset;
      pat_high = PatHighReset;
      pat_len  = PatLenReset;
      clear_stream();
      pending_decodes.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_PAT_LOW:  pat_low  = cfg_data_i;
          REG_PAT_HIGH: pat_high = cfg_data_i[55:0];
          REG_PAT_LEN:  pat_len  = cfg_data_i[3:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        pending_decodes.push_back(decode_and_match(s_axis_tuser, s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) check_result();
    end
    outstanding = pending_decodes.size();
  end

endmodule

>>> dv/uri_decode_pattern_matcher_test.sv
// ----------------------------------------------------------------------------
// uri_decode_pattern_matcher_test
// Drives percent-encoded byte streams with end-of-stream words into the
// matcher under bursty input and a stalling output, across pattern settings
// from length 0 to 15, and reports the verdict of the stream checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module uri_decode_pattern_matcher_test;
  import udpm_pkg::*;

  localparam int QuietLimit = 1000;
  localparam int PhaseWords = 60;
  localparam logic [CfgIdxWidth-1:0] RegIdxSpare = 2'd3;
  localparam logic [7:0] PrintLo = 8'h20;
  localparam logic [7:0] PrintHi = 8'h7E;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [7:0]              s_axis_tdata  = '0;  // data_byte
  logic                    s_axis_tuser  = OP_DATA;  // op
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [15:0]             m_axis_tdata;  // matched, decoded_byte
  logic                    m_axis_tuser;  // byte_valid
  logic                    m_axis_tlast;
  logic                    cfg_we_i      = 1'b0;
  logic [CfgIdxWidth-1:0]  cfg_idx_i     = '0;
  logic [CfgDataWidth-1:0] cfg_data_i    = '0;

  int fail_count;
  int outstanding;
  int results_seen;
  int streams_closed;
  int stream_hits;

  int         words_sent   = 0;
  int         burst_left   = 0;
  int         quiet_cycles = 0;
  int         settings_run = 0;
  int         stall_mode   = 0;
  int         mode_left    = 0;
  int         stall_left   = 0;
  int         pat_len_now  = 0;
  logic [7:0] pat_bytes [15];
  string      hex_digits   = "0123456789abcdef";

  always #10 clk_i = ~clk_i;

  uri_decode_pattern_matcher uut (.*);

  udpm_stream_checker u_checker (.*);

  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left  = $urandom_range(32, 160);
    end
    mode_left--;
    if (stall_left != 0) stall_left--;
    else if (stall_mode == 1 && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 3);
    else if (stall_mode == 2 && $urandom_range(0, 1) == 0) stall_left = $urandom_range(1, 8);
    m_axis_tready <= (stall_left == 0);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QuietLimit) begin
      $display("Watchdog: no word moved for %0d cycles", QuietLimit);
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic is_hex_char(input logic [7:0] c);
    return (c >= CharZero && c <= CharNine) ||
           ((c | CaseBit) >= CharLoA && (c | CaseBit) <= CharLoF);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    c = hex_digits[nib];
    if (c >= CharLoA && $urandom_range(0, 1) == 1) c = c & ~CaseBit;
    return c;
  endfunction

  function automatic logic [63:0] pattern_word(input bit text);
    logic [63:0] w;
    w = {$urandom, $urandom};
    if (text) begin
      for (int i = 0; i < 8; i++) w[8*i +: 8] = $urandom_range(PrintHi, PrintLo);
    end
    return w;
  endfunction

  // hold the input low until every pending result word has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
  endtask

  task automatic send_word(input logic op, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end else if ($urandom_range(0, 63) == 0) begin
      wait_drained();
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(OP_DATA, s[i]);
  endtask

  task automatic end_stream();
    send_word(OP_END, 8'($urandom));
  endtask

  task automatic send_escaped(input logic [7:0] b);
    send_word(OP_DATA, CharPct);
    send_word(OP_DATA, hex_char(b[7:4]));
    send_word(OP_DATA, hex_char(b[3:0]));
  endtask

  task automatic send_pattern_byte(input logic [7:0] p);
    logic [7:0] d;
    int         pick;
    d    = p;
    pick = $urandom_range(0, 9);
    if ((p | CaseBit) >= CharLoA && (p | CaseBit) <= (CharUpZ | CaseBit) &&
        $urandom_range(0, 1) == 1) d = p ^ CaseBit;
    if (d == CharPct) begin
      if (pick < 5) begin
        send_word(OP_DATA, CharPct);
        send_word(OP_DATA, CharPct);
      end else begin
        send_escaped(d);
      end
    end else if (pick < 5) begin
      send_word(OP_DATA, d);
    end else if (pick < 8 || is_hex_char(d)) begin
      send_escaped(d);
    end else begin
      send_word(OP_DATA, CharPct);
      send_word(OP_DATA, d);
    end
  endtask

  task automatic send_stream();
    int segs;
    int kind;
    int n;
    segs = $urandom_range(1, 4);
    repeat (segs) begin
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        for (int i = 0; i < pat_len_now; i++) send_pattern_byte(pat_bytes[i]);
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 6)) send_word(OP_DATA, 8'($urandom));
      end else if (kind == 8) begin
        n = $urandom_range(0, pat_len_now);
        for (int i = 0; i < n; i++) send_pattern_byte(pat_bytes[i]);
      end else begin
        send_word(OP_DATA, CharPct);
        if ($urandom_range(0, 1) == 1) send_word(OP_DATA, hex_char(4'($urandom)));
        send_word(OP_DATA, 8'($urandom));
      end
    end
    if ($urandom_range(0, 7) == 0) begin
      send_word(OP_DATA, CharPct);
      if ($urandom_range(0, 1) == 1) send_word(OP_DATA, hex_char(4'($urandom)));
    end
    end_stream();
  endtask

  task automatic load_pattern_copy(input logic [63:0] low, input logic [63:0] high,
                                   input logic [3:0] len);
    for (int i = 0; i < 8; i++) pat_bytes[i] = low[8*i +: 8];
    for (int i = 8; i < 15; i++) pat_bytes[i] = high[8*(i-8) +: 8];
    pat_len_now = len;
    settings_run++;
  endtask

  task automatic program_pattern(input logic [63:0] low, input logic [63:0] high,
                                 input logic [3:0] len, input bit spare);
    wait_drained();
    repeat (2) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_PAT_LOW;
    cfg_data_i <= low;
    @(negedge clk_i);
    cfg_idx_i  <= REG_PAT_HIGH;
    cfg_data_i <= high;
    @(negedge clk_i);
    cfg_idx_i  <= REG_PAT_LEN;
    cfg_data_i <= {$urandom, 28'($urandom), len};
    @(negedge clk_i);
    if (spare) begin
      cfg_idx_i  <= RegIdxSpare;
      cfg_data_i <= {$urandom, $urandom};
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    load_pattern_copy(low, high, len);
  endtask

  task automatic run_phase();
    int target;
    target = words_sent + PhaseWords;
    while (words_sent < target) send_stream();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    load_pattern_copy(PatLowReset, {8'h00, PatHighReset}, PatLenReset);
    @(negedge clk_i);

    send_text("SkEl-%4DArKeR");
    end_stream();
    send_word(OP_DATA, 8'h00);
    send_word(OP_DATA, 8'hFF);
    send_text("%%%G%4Z%fF%");
    end_stream();
    send_text("%a");
    end_stream();

    run_phase();
    program_pattern(pattern_word(1'b1), pattern_word(1'b1), 4'd0, 1'b1);
    run_phase();
    program_pattern(pattern_word(1'b1), pattern_word(1'b0), 4'd1, 1'b0);
    run_phase();
    program_pattern('1, '1, 4'd15, 1'b0);
    run_phase();
    program_pattern('0, '0, 4'd15, 1'b0);
    run_phase();
    repeat (6) begin
      program_pattern(pattern_word($urandom_range(0, 1)), pattern_word($urandom_range(0, 1)),
                      4'($urandom_range(1, 15)), 1'b0);
      run_phase();
    end
    program_pattern(PatLowReset, {8'h00, PatHighReset}, PatLenReset, 1'b0);
    run_phase();

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("Covered %0d input words and %0d result words over %0d pattern settings.",
             words_sent, results_seen, settings_run);
    $display("Closed %0d streams, %0d of them with the pattern found.",
             streams_closed, stream_hits);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
